[rtl/core/gtgi_pkg.sv]
// ----------------------------------------------------------------------------
// gtgi_pkg - gain table gap interpolator shared definitions
// Table geometry, gain widths, divider widths and item action codes.
// ----------------------------------------------------------------------------
package gtgi_pkg;

    localparam int unsigned CHANNELS = 64;
    localparam int unsigned CH_W     = $clog2(CHANNELS);
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned LANES    = 3;
    localparam int unsigned ENTRY_W  = LANES * GAIN_W;

    // (y2 - y1) * (x - x1): difference of two gains times a signed channel offset
    localparam int unsigned DY_W     = GAIN_W + 1;
    localparam int unsigned DX_W     = CH_W + 1;
    localparam int unsigned PROD_W   = DY_W + DX_W;
    localparam int unsigned NUM_W    = PROD_W;
    localparam int unsigned DEN_W    = CH_W;
    localparam int unsigned REM_W    = DEN_W + 1;
    localparam int unsigned QUO_W    = NUM_W + 1;
    localparam int unsigned SUM_W    = QUO_W + 1;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FILL  = 2'd2;

endpackage

[rtl/core/gtgi_if.sv]
// ----------------------------------------------------------------------------
// gtgi_if - gain table gap interpolator channels
// Valid/ready channels for the command beat and the dumped table entry beat.
// ----------------------------------------------------------------------------
interface gtgi_in_if import gtgi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic [CH_W-1:0]          channel;
    logic signed [GAIN_W-1:0] siso_in;
    logic signed [GAIN_W-1:0] wide_in;
    logic signed [GAIN_W-1:0] wide_link_in;

    modport source (output valid, action, channel, siso_in, wide_in, wide_link_in,
                    input ready);
    modport sink   (input valid, action, channel, siso_in, wide_in, wide_link_in,
                    output ready);
endinterface

interface gtgi_out_if import gtgi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          out_channel;
    logic                     known;
    logic signed [GAIN_W-1:0] siso_out;
    logic signed [GAIN_W-1:0] wide_out;
    logic signed [GAIN_W-1:0] wide_link_out;
    logic                     last_entry;

    modport source (output valid, out_channel, known, siso_out, wide_out, wide_link_out,
                    last_entry, input ready);
    modport sink   (input valid, out_channel, known, siso_out, wide_out, wide_link_out,
                    last_entry, output ready);
endinterface

[rtl/core/gtgi_div.sv]
// ----------------------------------------------------------------------------
// gtgi_div - unsigned restoring divider
// One quotient bit per cycle; done pulses once when the quotient is ready.
// ----------------------------------------------------------------------------
module gtgi_div import gtgi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int unsigned CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_den;

    logic [REM_W-1:0] trial;
    logic             fits;

    assign trial = {r_rem[REM_W-2:0], r_quot[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift in one numerator bit, subtract where the divisor fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quot <= {r_quot[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[rtl/core/gain_table_gap_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// gain_table_gap_interpolator_unit - per-channel gain table with gap filling
// Stores three Q8.8 dB gains and a known flag per channel, fills gaps by
// linear interpolation through a shared multiply and divide unit, dumps table.
// ----------------------------------------------------------------------------
// A clear or write beat is taken in S_IDLE, where the block stays ready for
// the next beat. A fill beat blocks input until the whole 64-entry dump has
// been taken: the scan visits each unknown channel in S_SCAN and each known
// one in S_SCAN and S_LOAD; each filled channel runs, for each of the three
// gains in turn, one multiply, one divider start, 24 radix-2 divider
// iterations and the done pulse, then one write-back; and each dumped beat
// passes S_DUMP_RD, S_DUMP_LD and S_DUMP_WAIT, where it waits out any
// back-pressure. Most of a filled channel's time goes to the shared restoring
// divider. The gains are held in a table memory with one write port and a
// registered read; stored values are only ever read behind a set known flag.
// ----------------------------------------------------------------------------
module gain_table_gap_interpolator_unit import gtgi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gtgi_in_if.sink     i_in,
    gtgi_out_if.source  o_out
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_SCAN      = 11'b000_0000_0010,
        S_LOAD      = 11'b000_0000_0100,
        S_EDGE      = 11'b000_0000_1000,
        S_MUL       = 11'b000_0001_0000,
        S_DIVGO     = 11'b000_0010_0000,
        S_DIV       = 11'b000_0100_0000,
        S_WRITE     = 11'b000_1000_0000,
        S_DUMP_RD   = 11'b001_0000_0000,
        S_DUMP_LD   = 11'b010_0000_0000,
        S_DUMP_WAIT = 11'b100_0000_0000
    } t_state;

    localparam logic [1:0] LANE_LAST = 2'(LANES - 1);

    // gain table: lane 0 single-stream, lane 1 wide-band, lane 2 wide-band link
    logic [ENTRY_W-1:0] r_mem [CHANNELS];
    logic [ENTRY_W-1:0] r_rdata;
    logic [CHANNELS-1:0] r_known;

    t_state r_state, n_state;

    logic [CH_W-1:0]    r_i;
    logic               r_prev_v, r_first_v, r_second_v, r_extrap;
    logic [CH_W-1:0]    r_prev, r_first, r_second;
    logic [ENTRY_W-1:0] r_yprev, r_yfirst, r_ysecond;

    // current interpolation run
    logic [CH_W-1:0]          r_x1, r_x2, r_j, r_j_end;
    logic [ENTRY_W-1:0]       r_ya, r_yb, r_res;
    logic [1:0]               r_lane;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [GAIN_W-1:0] r_y1;
    logic                     r_neg;

    // output register
    logic                     r_out_valid;
    logic [CH_W-1:0]          r_out_ch;
    logic                     r_out_known;
    logic [ENTRY_W-1:0]       r_out_gain;
    logic                     r_out_last;

    logic                     mem_we;
    logic [CH_W-1:0]          mem_waddr;
    logic [ENTRY_W-1:0]       mem_wdata;

    logic                     in_beat;
    logic                     fill_gap, do_extrap, run_end, scan_last;
    logic signed [GAIN_W-1:0] ya_l, yb_l;
    logic signed [DY_W-1:0]   dy;
    logic signed [DX_W-1:0]   dx;
    logic signed [PROD_W-1:0] prod;
    logic [NUM_W-1:0]         div_num;
    logic                     div_start, div_done;
    logic [NUM_W-1:0]         div_quot;
    logic signed [QUO_W-1:0]  q_signed;
    logic signed [SUM_W-1:0]  sum;
    logic signed [GAIN_W-1:0] lane_res;

    function automatic logic signed [GAIN_W-1:0] f_lane(input logic [ENTRY_W-1:0] e,
                                                        input logic [1:0] lane);
        logic signed [GAIN_W-1:0] g;
        case (lane)
            2'd0:    g = e[GAIN_W-1:0];
            2'd1:    g = e[2*GAIN_W-1:GAIN_W];
            2'd2:    g = e[3*GAIN_W-1:2*GAIN_W];
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic logic signed [GAIN_W-1:0] f_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed({{(SUM_W-GAIN_W+1){1'b0}}, {(GAIN_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return hi[GAIN_W-1:0];
        end else if (v < lo) begin
            return lo[GAIN_W-1:0];
        end
        return v[GAIN_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // handshake and sequencing conditions
    // ------------------------------------------------------------------
    assign i_in.ready = (r_state == S_IDLE);
    assign in_beat    = i_in.valid && i_in.ready;

    assign scan_last = (r_i == LAST_CH);
    // a known channel closes a gap when channels lie between it and the last one
    assign fill_gap  = r_prev_v && (r_i != (r_prev + CH_W'(1)));
    // extrapolate leading channels only from two known points, first not at zero
    assign do_extrap = r_first_v && r_second_v && (r_first != '0);
    assign run_end   = ((r_j + CH_W'(1)) == r_j_end);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_beat && i_in.action == ACT_FILL) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_known[r_i]) n_state = S_LOAD;
                else if (scan_last) n_state = S_EDGE;
            end
            S_LOAD: begin
                if (fill_gap) n_state = S_MUL;
                else if (scan_last) n_state = S_EDGE;
                else n_state = S_SCAN;
            end
            S_EDGE: begin
                n_state = do_extrap ? S_MUL : S_DUMP_RD;
            end
            S_MUL:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV: begin
                if (div_done) n_state = (r_lane == LANE_LAST) ? S_WRITE : S_MUL;
            end
            S_WRITE: begin
                if (!run_end) n_state = S_MUL;
                else if (r_extrap) n_state = S_DUMP_RD;
                else if (scan_last) n_state = S_EDGE;
                else n_state = S_SCAN;
            end
            S_DUMP_RD: n_state = S_DUMP_LD;
            S_DUMP_LD: n_state = S_DUMP_WAIT;
            S_DUMP_WAIT: begin
                if (o_out.ready) n_state = scan_last ? S_IDLE : S_DUMP_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // shared arithmetic: one multiply, then the divider, one lane at a time
    // ------------------------------------------------------------------
    assign ya_l = f_lane(r_ya, r_lane);
    assign yb_l = f_lane(r_yb, r_lane);
    assign dy   = DY_W'(yb_l) - DY_W'(ya_l);
    assign dx   = $signed({1'b0, r_j}) - $signed({1'b0, r_x1});
    assign prod = dy * dx;

    // divide magnitudes so the quotient truncates toward zero; take the sign
    // straight from the product, as r_neg only settles at the start edge
    assign div_start = (r_state == S_DIVGO);
    assign div_num   = r_prod[PROD_W-1] ? NUM_W'(-r_prod) : NUM_W'(r_prod);

    gtgi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_x2 - r_x1),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign q_signed = r_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    assign sum      = SUM_W'(r_y1) + SUM_W'(q_signed);
    assign lane_res = f_sat(sum);

    // ------------------------------------------------------------------
    // table memory: one write port, registered read at the walk index
    // ------------------------------------------------------------------
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = r_res;
        if (r_state == S_IDLE && in_beat && i_in.action == ACT_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = i_in.channel;
            mem_wdata = {i_in.wide_link_in, i_in.wide_in, i_in.siso_in};
        end else if (r_state == S_WRITE) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_i];
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_known     <= '0;
            r_i         <= '0;
            r_prev_v    <= 1'b0;
            r_first_v   <= 1'b0;
            r_second_v  <= 1'b0;
            r_extrap    <= 1'b0;
            r_lane      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        case (i_in.action)
                            ACT_CLEAR: r_known <= '0;
                            ACT_WRITE: r_known[i_in.channel] <= 1'b1;
                            ACT_FILL: begin
                                r_i        <= '0;
                                r_prev_v   <= 1'b0;
                                r_first_v  <= 1'b0;
                                r_second_v <= 1'b0;
                                r_extrap   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    // advance past unknown channels
                    if (!r_known[r_i] && !scan_last) r_i <= r_i + CH_W'(1);
                end
                S_LOAD: begin
                    if (!r_first_v) begin
                        r_first_v <= 1'b1;
                    end else if (!r_second_v) begin
                        r_second_v <= 1'b1;
                    end
                    r_prev_v <= 1'b1;
                    r_lane   <= '0;
                    if (!fill_gap && !scan_last) r_i <= r_i + CH_W'(1);
                end
                S_EDGE: begin
                    r_lane <= '0;
                    if (do_extrap) begin
                        r_extrap <= 1'b1;
                    end else begin
                        r_i <= '0;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_lane <= (r_lane == LANE_LAST) ? '0 : r_lane + 2'd1;
                    end
                end
                S_WRITE: begin
                    r_known[r_j] <= 1'b1;
                    if (run_end) begin
                        if (r_extrap) begin
                            r_i <= '0;
                        end else if (!scan_last) begin
                            r_i <= r_i + CH_W'(1);
                        end
                    end
                end
                S_DUMP_LD: begin
                    r_out_valid <= 1'b1;
                end
                S_DUMP_WAIT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (!scan_last) r_i <= r_i + CH_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers (no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                // capture the first two known points for leading extrapolation
                if (!r_first_v) begin
                    r_first  <= r_i;
                    r_yfirst <= r_rdata;
                end else if (!r_second_v) begin
                    r_second  <= r_i;
                    r_ysecond <= r_rdata;
                end
                if (fill_gap) begin
                    r_x1    <= r_prev;
                    r_x2    <= r_i;
                    r_ya    <= r_yprev;
                    r_yb    <= r_rdata;
                    r_j     <= r_prev + CH_W'(1);
                    r_j_end <= r_i;
                end
                r_prev  <= r_i;
                r_yprev <= r_rdata;
            end
            S_EDGE: begin
                r_x1    <= r_first;
                r_x2    <= r_second;
                r_ya    <= r_yfirst;
                r_yb    <= r_ysecond;
                r_j     <= '0;
                r_j_end <= r_first;
            end
            S_MUL: begin
                r_prod <= prod;
                r_y1   <= ya_l;
            end
            S_DIVGO: begin
                r_neg <= r_prod[PROD_W-1];
            end
            S_DIV: begin
                if (div_done) begin
                    case (r_lane)
                        2'd0:    r_res[GAIN_W-1:0]          <= lane_res;
                        2'd1:    r_res[2*GAIN_W-1:GAIN_W]   <= lane_res;
                        2'd2:    r_res[3*GAIN_W-1:2*GAIN_W] <= lane_res;
                        default: ;
                    endcase
                end
            end
            S_WRITE: begin
                if (!run_end) r_j <= r_j + CH_W'(1);
            end
            S_DUMP_LD: begin
                // unknown entries read as zero gains
                r_out_ch    <= r_i;
                r_out_known <= r_known[r_i];
                r_out_gain  <= r_known[r_i] ? r_rdata : '0;
                r_out_last  <= scan_last;
            end
            default: ;
        endcase
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_channel   = r_out_ch;
    assign o_out.known         = r_out_known;
    assign o_out.siso_out      = r_out_gain[GAIN_W-1:0];
    assign o_out.wide_out      = r_out_gain[2*GAIN_W-1:GAIN_W];
    assign o_out.wide_link_out = r_out_gain[3*GAIN_W-1:2*GAIN_W];
    assign o_out.last_entry    = r_out_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_accept_during_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("command accepted while a dump beat is pending");

    a_fill_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> r_known[$past(r_j)])
        else $error("filled channel not marked known");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> !div_done)
        else $error("divider finished immediately after start");

    a_last_beat_ends_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_entry) |=> (r_state == S_IDLE))
        else $error("dump did not end on the final entry");

endmodule

[tb/gain_table_dump_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_table_dump_checker - scoreboard for the gain table gap interpolator
// Keeps a copy of the gain table built from the command beats it sees.
// Predicts every entry of each dump and checks accepted dump beats in order.
// ----------------------------------------------------------------------------
module gain_table_dump_checker import gtgi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    gtgi_in_if   i_cmd,
    gtgi_out_if  i_dump,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_entries
);

    localparam longint GAIN_MAX = (longint'(1) <<< (GAIN_W - 1)) - 1;
    localparam longint GAIN_MIN = -GAIN_MAX - 1;

    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic                     known;
        logic signed [GAIN_W-1:0] siso;
        logic signed [GAIN_W-1:0] wide;
        logic signed [GAIN_W-1:0] wide_link;
        logic                     last;
    } t_table_entry;

    logic                     known_map [CHANNELS];
    logic signed [GAIN_W-1:0] gain_map  [CHANNELS][LANES];
    t_table_entry             dump_q[$];
    int                       fail_cnt  = 0;
    int                       entry_cnt = 0;

    // Multiply first, divide with truncation toward zero, then saturate.
    function automatic logic signed [GAIN_W-1:0] interp_gain(
        input longint y1, input longint y2,
        input longint x1, input longint x2, input longint x);
        longint v;
        v = y1 + ((y2 - y1) * (x - x1)) / (x2 - x1);
        if (v > GAIN_MAX)
            v = GAIN_MAX;
        else if (v < GAIN_MIN)
            v = GAIN_MIN;
        return v[GAIN_W-1:0];
    endfunction

    task automatic fill_from(input int j, input int a, input int b);
        for (int l = 0; l < LANES; l++)
            gain_map[j][l] = interp_gain(gain_map[a][l], gain_map[b][l], a, b, j);
        known_map[j] = 1'b1;
    endtask

    task automatic fill_gaps();
        int first;
        int second;
        int prev;
        first  = -1;
        second = -1;
        prev   = -1;
        for (int i = 0; i < CHANNELS; i++) begin
            if (known_map[i]) begin
                if (first < 0)
                    first = i;
                else if (second < 0)
                    second = i;
            end
        end
        for (int i = 0; i < CHANNELS; i++) begin
            if (known_map[i]) begin
                if (prev >= 0)
                    for (int j = prev + 1; j < i; j++)
                        fill_from(j, prev, i);
                prev = i;
            end
        end
        // leading channels only with two points to draw a line through
        if (first > 0 && second > first)
            for (int j = 0; j < first; j++)
                fill_from(j, first, second);
    endtask

    task automatic queue_dump();
        t_table_entry e;
        for (int i = 0; i < CHANNELS; i++) begin
            e.channel   = CH_W'(i);
            e.known     = known_map[i];
            e.siso      = known_map[i] ? gain_map[i][0] : '0;
            e.wide      = known_map[i] ? gain_map[i][1] : '0;
            e.wide_link = known_map[i] ? gain_map[i][2] : '0;
            e.last      = (i == CHANNELS - 1);
            dump_q.push_back(e);
        end
    endtask

    task automatic check_field(input string name, input int ch,
                               input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch on channel %0d: expected %0d, got %0d",
                   name, ch, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : mirror
        t_table_entry e;
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++)
                known_map[i] = 1'b0;
            dump_q.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.action)
                    ACT_CLEAR: begin
                        for (int i = 0; i < CHANNELS; i++)
                            known_map[i] = 1'b0;
                    end
                    ACT_WRITE: begin
                        gain_map[i_cmd.channel][0] = i_cmd.siso_in;
                        gain_map[i_cmd.channel][1] = i_cmd.wide_in;
                        gain_map[i_cmd.channel][2] = i_cmd.wide_link_in;
                        known_map[i_cmd.channel]   = 1'b1;
                    end
                    ACT_FILL: begin
                        fill_gaps();
                        queue_dump();
                    end
                    default: ;
                endcase
            end
            if (i_dump.valid && i_dump.ready) begin
                entry_cnt++;
                if (dump_q.size() == 0) begin
                    $error("unexpected dump beat for channel %0d", i_dump.out_channel);
                    fail_cnt++;
                end else begin
                    e = dump_q.pop_front();
                    check_field("out_channel", e.channel, e.channel, i_dump.out_channel);
                    check_field("known", e.channel, e.known, i_dump.known);
                    check_field("siso_out", e.channel, e.siso, i_dump.siso_out);
                    check_field("wide_out", e.channel, e.wide, i_dump.wide_out);
                    check_field("wide_link_out", e.channel, e.wide_link,
                                i_dump.wide_link_out);
                    check_field("last_entry", e.channel, e.last, i_dump.last_entry);
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= dump_q.size();
        o_entries    <= entry_cnt;
    end

endmodule

[tb/gain_table_gap_interpolator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_table_gap_interpolator_unit_tb - testbench for the gap interpolator
// Drives clear, write and fill commands in random bursts against a stalling
// dump receiver; the checker predicts each dumped table and counts mismatches.
// ----------------------------------------------------------------------------
module gain_table_gap_interpolator_unit_tb;
    import gtgi_pkg::*;

    // Action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         RANDOM_ITEMS = 500;

    localparam logic signed [GAIN_W-1:0] GAIN_TOP    = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic signed [GAIN_W-1:0] GAIN_BOTTOM = {1'b1, {(GAIN_W-1){1'b0}}};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int pending;
    int entries_checked;
    int beats_sent  = 0;
    int fills_sent  = 0;
    int burst_left  = 0;

    gtgi_in_if  cmd_if ();
    gtgi_out_if dump_if ();

    gain_table_gap_interpolator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (dump_if)
    );

    gain_table_dump_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_dump       (dump_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_entries    (entries_checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop: generous over the slowest legal run (every command a fill of
    // a near-full table behind a heavily stalling receiver).
    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Mostly random values, with the range ends, zero and +/-1 well represented
    function automatic logic signed [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 9))
            0:       return GAIN_TOP;
            1:       return GAIN_BOTTOM;
            2:       return '0;
            3:       return $urandom_range(0, 1) ? '1 : GAIN_W'(1);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // Present one command beat and hold it until the block takes it. Between
    // bursts drop valid for a random gap; some bursts run long with no gap.
    task automatic send_beat(input logic [1:0] act, input logic [CH_W-1:0] ch,
                             input logic signed [GAIN_W-1:0] s,
                             input logic signed [GAIN_W-1:0] w,
                             input logic signed [GAIN_W-1:0] wl);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.action       <= act;
        cmd_if.channel      <= ch;
        cmd_if.siso_in      <= s;
        cmd_if.wide_in      <= w;
        cmd_if.wide_link_in <= wl;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        burst_left--;
        if (act != ACT_UNUSED)
            beats_sent++;
        if (act == ACT_FILL)
            fills_sent++;
    endtask

    // Drop valid and hold off until every predicted dump entry has been taken.
    // The first edge lets the checker's count catch up with the last beat.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Dump receiver: switch between free flow, random stalls, sparse accepts
    // and a fixed on/off rhythm, each for a random stretch of cycles.
    initial begin
        int stall_left;
        int stall_mode;
        int tick;
        stall_left    = 0;
        stall_mode    = 0;
        tick          = 0;
        dump_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 200);
            end
            stall_left--;
            tick++;
            case (stall_mode)
                0:       dump_if.ready <= 1'b1;
                1:       dump_if.ready <= ($urandom_range(0, 1) == 1);
                2:       dump_if.ready <= ($urandom_range(0, 3) == 0);
                default: dump_if.ready <= ((tick % 6) < 3);
            endcase
        end
    end

    initial begin
        int n_writes;
        int span;
        int lo_ch;
        int start_beats;

        cmd_if.valid        = 1'b0;
        cmd_if.action       = ACT_CLEAR;
        cmd_if.channel      = '0;
        cmd_if.siso_in      = '0;
        cmd_if.wide_in      = '0;
        cmd_if.wide_link_in = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---------------------------------------------------
        // Dump straight after reset: nothing known, nothing filled.
        send_beat(ACT_FILL, CH_W'($urandom), rand_gain(), rand_gain(), rand_gain());

        // Single measured point: no extrapolation, the rest stays unknown.
        send_beat(ACT_WRITE, CH_W'(0), GAIN_TOP, GAIN_BOTTOM, '0);
        send_beat(ACT_FILL, CH_W'($urandom), rand_gain(), rand_gain(), rand_gain());

        // Unused action code: must leave no trace.
        send_beat(ACT_UNUSED, CH_W'($urandom), rand_gain(), rand_gain(), rand_gain());

        // Steep slope from opposite range ends: extrapolated leading channels
        // saturate, channels past the last point stay unknown.
        send_beat(ACT_CLEAR, CH_W'($urandom), rand_gain(), rand_gain(), rand_gain());
        send_beat(ACT_WRITE, CH_W'(10), GAIN_BOTTOM, GAIN_TOP, '1);
        send_beat(ACT_WRITE, CH_W'(20), GAIN_TOP, GAIN_BOTTOM, GAIN_W'(1));
        send_beat(ACT_FILL, CH_W'($urandom), rand_gain(), rand_gain(), rand_gain());

        // Extend to the top channel; earlier filled entries now count as known.
        send_beat(ACT_WRITE, CH_W'(63), '0, -GAIN_W'(256), GAIN_W'(256));
        send_beat(ACT_WRITE, CH_W'(40), GAIN_W'(128), -GAIN_W'(128), GAIN_TOP);
        send_beat(ACT_FILL, CH_W'($urandom), rand_gain(), rand_gain(), rand_gain());

        // Clear hides the stored gains.
        send_beat(ACT_CLEAR, CH_W'($urandom), rand_gain(), rand_gain(), rand_gain());
        send_beat(ACT_FILL, CH_W'($urandom), rand_gain(), rand_gain(), rand_gain());

        // Overwrite a channel, then two adjacent points at the very top:
        // no interior gap, every lower channel extrapolated.
        send_beat(ACT_WRITE, CH_W'(62), rand_gain(), rand_gain(), rand_gain());
        send_beat(ACT_WRITE, CH_W'(62), rand_gain(), rand_gain(), rand_gain());
        send_beat(ACT_WRITE, CH_W'(63), rand_gain(), rand_gain(), rand_gain());
        send_beat(ACT_FILL, CH_W'($urandom), rand_gain(), rand_gain(), rand_gain());

        // Full-width interpolation between the two end channels.
        send_beat(ACT_CLEAR, CH_W'($urandom), rand_gain(), rand_gain(), rand_gain());
        send_beat(ACT_WRITE, CH_W'(0), GAIN_BOTTOM, GAIN_BOTTOM, GAIN_TOP);
        send_beat(ACT_WRITE, CH_W'(63), GAIN_TOP, GAIN_TOP, GAIN_BOTTOM);
        send_beat(ACT_FILL, CH_W'($urandom), rand_gain(), rand_gain(), rand_gain());

        // Hold the sender until the directed dumps are all in.
        wait_drained();

        // --- random part -----------------------------------------------------
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    // Calibration load: clear (usually), a few measured
                    // channels, then fill. Half the loads keep their points
                    // in a narrow window so the interior gaps stay short.
                    if ($urandom_range(0, 4) != 0)
                        send_beat(ACT_CLEAR, CH_W'($urandom), rand_gain(), rand_gain(),
                                  rand_gain());
                    n_writes = $urandom_range(0, 6);
                    span     = $urandom_range(0, 1) ? CHANNELS : $urandom_range(2, 16);
                    lo_ch    = $urandom_range(0, CHANNELS - span);
                    repeat (n_writes)
                        send_beat(ACT_WRITE, CH_W'(lo_ch + $urandom_range(0, span - 1)),
                                  rand_gain(), rand_gain(), rand_gain());
                    send_beat(ACT_FILL, CH_W'($urandom), rand_gain(), rand_gain(),
                              rand_gain());
                end
                7, 8: begin
                    // Noise: any action code, any fields.
                    repeat ($urandom_range(1, 4))
                        send_beat(2'($urandom_range(0, 3)), CH_W'($urandom),
                                  rand_gain(), rand_gain(), rand_gain());
                end
                default: begin
                    // Broken load: points written, then cleared, sometimes one more point, then fill.
                    repeat ($urandom_range(1, 4))
                        send_beat(ACT_WRITE, CH_W'($urandom), rand_gain(), rand_gain(),
                                  rand_gain());
                    send_beat(ACT_CLEAR, CH_W'($urandom), rand_gain(), rand_gain(),
                              rand_gain());
                    if ($urandom_range(0, 1) == 1)
                        send_beat(ACT_WRITE, CH_W'($urandom), rand_gain(), rand_gain(),
                                  rand_gain());
                    send_beat(ACT_FILL, CH_W'($urandom), rand_gain(), rand_gain(),
                              rand_gain());
                end
            endcase
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end

        // --- wind down -------------------------------------------------------
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d command beats including %0d fill-and-dump commands,",
                 beats_sent, fills_sent);
        $display("with %0d dumped table entries checked against the prediction.",
                 entries_checked);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
rtl/core/gtgi_pkg.sv
rtl/core/gtgi_if.sv
rtl/core/gtgi_div.sv
rtl/core/gain_table_gap_interpolator_unit.sv
tb/gain_table_dump_checker.sv
tb/gain_table_gap_interpolator_unit_tb.sv
